[hw/rtl/fit_policy_block_allocator_defines.svh]
// Assertion macros shared by the allocator checker.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define FPBA_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("allocator check failed");

// Condition must hold in the cycle after the trigger.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("allocator check failed");

`endif

[hw/rtl/fpba_pkg.sv]
// Shared constants, types and codes of the fit-policy block allocator.
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // Fixed port widths.
    localparam int SEL_BITS = 4;
    localparam int VAL_BITS = 16;
    localparam int POL_BITS = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 5;

    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef logic [BLK_W-1:0]     blk_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SIZE_BITS-1:0] room_t;
    typedef logic [POL_BITS-1:0]  policy_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam policy_t POLICY_FIRST = 2'd0;
    localparam policy_t POLICY_BEST  = 2'd1;
    localparam policy_t POLICY_WORST = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_IN_USE = 2'd1;

    // Running candidate of a scan.
    typedef struct packed {
        logic  have;
        blk_t  sel;
        room_t best;
    } scan_t;

endpackage

[hw/rtl/fpba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fpba_scan.sv]
// Candidate tracker: folds one read entry per cycle, while step is high, into the current pick.
module fpba_scan import fpba_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear,
    input  logic    step,
    input  room_t   room,
    input  blk_t    idx,
    input  room_t   need,
    input  policy_t policy,
    output scan_t   pick
);

    scan_t pick_reg;
    scan_t pick_next;
    logic  fits;
    logic  take;

    assign fits = (room >= need);

    // Policy code three falls back to first fit: only the first fit is kept.
    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!pick_reg.have)
            begin
                take = 1'b1;
            end
            else if (policy == POLICY_BEST)
            begin
                take = (room < pick_reg.best);
            end
            else if (policy == POLICY_WORST)
            begin
                take = (room > pick_reg.best);
            end
        end
    end

    always_comb
    begin
        pick_next = pick_reg;
        if (clear)
        begin
            pick_next.have = 1'b0;
        end
        else if (step && take)
        begin
            pick_next.have = 1'b1;
            pick_next.sel  = idx;
            pick_next.best = room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
        end
        else
        begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule

[hw/rtl/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: sequencer, free-space RAM and config.
//
// A load request (operation 0) writes one free-space entry in the cycle it is
// accepted; busy stays low and no result follows. An allocate request
// (operation 1) reads N entries out of the free-space RAM one per cycle and
// keeps busy high through its scan, drain and write states, N being blocks_in_use
// capped at the table size of 16 entries (N = 0 skips the scan and is
// refused). The result appears on granted, chosen_block and space_left for the
// single cycle in which done is high, which is also the first cycle busy is low
// again; the receiver must take it then. The free-space table reads as zero
// after reset. Configuration writes are always ready and belong in idle time.
module fit_policy_block_allocator import fpba_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic [SEL_BITS-1:0]      block_select,
    input  logic [VAL_BITS-1:0]      size_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     done,
    output logic                     granted,
    output logic [SEL_BITS-1:0]      chosen_block,
    output logic [VAL_BITS-1:0]      space_left
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    blk_t    idx_reg, idx_next;
    room_t   need_reg;
    logic    rd_pend_reg;
    blk_t    rd_idx_reg;
    logic [NUM_BLOCKS-1:0] vld_reg;
    policy_t policy_reg;
    logic [CFG_DATA_BITS-1:0] bu_reg;

    logic                done_reg, done_next;
    logic                granted_reg, granted_next;
    logic [SEL_BITS-1:0] chosen_reg, chosen_next;
    logic [VAL_BITS-1:0] left_reg, left_next;

    logic  accept;
    logic  load_ok;
    cnt_t  scan_limit;
    logic  last_issue;
    logic  ram_we;
    blk_t  ram_waddr;
    room_t ram_wdata;
    room_t ram_rdata;
    room_t room_in;
    room_t remain;
    scan_t pick;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign load_ok   = (32'(block_select) < NUM_BLOCKS);

    assign scan_limit = (32'(bu_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bu_reg);
    assign last_issue = ((CNT_W'(idx_reg) + CNT_W'(1)) == scan_limit);

    // Entries never written read as zero.
    assign room_in = vld_reg[rd_idx_reg] ? ram_rdata : '0;
    assign remain  = pick.best - need_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pick.sel;
        ram_wdata = remain;
        if (accept && (operation == OP_LOAD) && load_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = BLK_W'(block_select);
            ram_wdata = SIZE_BITS'(size_value);
        end
        else if ((state_reg == ST_WRITE) && pick.have)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept && (operation == OP_ALLOC))
                begin
                    state_next = (scan_limit == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + BLK_W'(1);
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done_next    = (state_reg == ST_WRITE);
        granted_next = pick.have;
        chosen_next  = pick.have ? SEL_BITS'(pick.sel) : '0;
        left_next    = pick.have ? VAL_BITS'(remain) : '0;
    end

    fpba_ram #(
        .WIDTH(SIZE_BITS),
        .DEPTH(NUM_BLOCKS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    fpba_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .step  (rd_pend_reg),
        .room  (room_in),
        .idx   (rd_idx_reg),
        .need  (need_reg),
        .policy(policy_reg),
        .pick  (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            vld_reg     <= '0;
            policy_reg  <= POLICY_FIRST;
            bu_reg      <= CFG_DATA_BITS'(16);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            done_reg    <= done_next;
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIT_POLICY)
                begin
                    policy_reg <= POL_BITS'(cfg_data);
                end
                else if (cfg_index == REG_BLOCKS_IN_USE)
                begin
                    bu_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (accept)
        begin
            need_reg <= SIZE_BITS'(size_value);
        end
        if (state_reg == ST_WRITE)
        begin
            granted_reg <= granted_next;
            chosen_reg  <= chosen_next;
            left_reg    <= left_next;
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign chosen_block = chosen_reg;
    assign space_left   = left_reg;

endmodule

[hw/rtl/fpba_checker.sv]
// Port-level checker for the allocator, bound to the top level.
`include "fit_policy_block_allocator_defines.svh"

module fpba_checker import fpba_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     operation,
    input logic                     done,
    input logic                     granted,
    input logic [SEL_BITS-1:0]      chosen_block,
    input logic [VAL_BITS-1:0]      space_left
);

    // A result shows only once the block is idle again.
    `FPBA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)

    // A refusal carries zero index and zero space.
    `FPBA_ASSERT_NOW(a_refuse_zero, clk, rst_n, done && !granted,
        (chosen_block == '0) && (space_left == '0))

    // An allocate request holds the block busy in the next cycle.
    `FPBA_ASSERT_NEXT(a_alloc_busy, clk, rst_n, start && !busy && (operation == OP_ALLOC), busy)

    // A load request gives no result and leaves the block idle.
    `FPBA_ASSERT_NEXT(a_load_quiet, clk, rst_n, start && !busy && (operation == OP_LOAD),
        !done && !busy)

    // Every end of an allocation delivers a result.
    `FPBA_ASSERT_NOW(a_end_result, clk, rst_n, $fell(busy), done)

endmodule

bind fit_policy_block_allocator fpba_checker u_checker (.*);
